// File: rtl/core/lsc_pkg.sv
// Shared types, constants and helpers of the lattice split checker.
// Depends on nothing; every other file of rtl/core refers to it by scoped names.
`timescale 1ns / 1ps

package lsc_pkg;

	localparam int MAX_SITES_DEF  = 4096;
	localparam int LABEL_BITS_DEF = 8;

	localparam int SITE_W   = 12;
	localparam int LABEL_W  = 8;
	localparam int DIM_W    = 7;
	localparam int POS_W    = 6;
	localparam int NB_IDX_W = 13;
	localparam int RING_N   = 8;
	localparam int DIR_W    = 3;

	localparam logic [DIM_W-1:0] DIM_MIN = 7'd3;
	localparam logic [DIM_W-1:0] DIM_MAX = 7'd64;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                op;
		logic [SITE_W-1:0]   site;
		logic [LABEL_W-1:0]  cell_label;
	} in_item_t;

	typedef struct packed {
		logic                split;
		logic [SITE_W-1:0]   query_site;
	} out_item_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DIV,
		S_RING_RD,
		S_RING_EV,
		S_RING_END,
		S_POP,
		S_POP_W,
		S_NB_RD,
		S_NB_EV,
		S_CLR_RD,
		S_CLR_WR,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_SWEEP,
		A_WRITE,
		A_QUERY,
		A_RING_BASE,
		A_NB_RD,
		A_RING_EV,
		A_SEED,
		A_POP_RD,
		A_POP_LATCH,
		A_NB_EV,
		A_FLOOD_END,
		A_CLR_RD,
		A_CLR_WR,
		A_LOAD_OUT
	} act_t;

	typedef struct packed {
		act_t act;
		logic in_take;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic div_busy;
		logic site_off;
		logic dir_last;
		logic entries_gt1;
		logic queue_empty;
		logic all_reached;
		logic clr_done;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic [DIM_W-1:0] nr;
		logic [DIM_W-1:0] nc;
	} nb_t;

	// Clamp a lattice dimension into 3..64.
	function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] d;
		if (v < DIM_MIN) d = DIM_MIN;
		else if (v > DIM_MAX) d = DIM_MAX;
		else d = v;
		return d;
	endfunction

	// Ring neighbour n of (r, c); -1 comes out as all ones, which fails any bound check.
	function automatic nb_t nb_step(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
			input logic [DIR_W-1:0] n);
		logic [DIM_W-1:0] dr;
		logic [DIM_W-1:0] dc;
		nb_t o;
		unique case (n)
			3'd0: begin dc = 7'h7F; dr = 7'd1; end
			3'd1: begin dc = 7'd0;  dr = 7'd1; end
			3'd2: begin dc = 7'd1;  dr = 7'd1; end
			3'd3: begin dc = 7'd1;  dr = 7'd0; end
			3'd4: begin dc = 7'd1;  dr = 7'h7F; end
			3'd5: begin dc = 7'd0;  dr = 7'h7F; end
			3'd6: begin dc = 7'h7F; dr = 7'h7F; end
			default: begin dc = 7'h7F; dr = 7'd0; end
		endcase
		o.nr = {1'b0, r} + dr;
		o.nc = {1'b0, c} + dc;
		return o;
	endfunction

endpackage

// File: rtl/core/lattice_split_check_core.sv
// Lattice split checker: a write item is stored when taken. A query runs a 12-step divide of
// its site into row and column, then goes to loading its result when the site is off the lattice,
// else runs the ring scan and, when the ring shows more than one entry, the flood and mark cleanup.
// One item is worked on at a time; the result register frees the output side.
// Reset (arst_n, async, active low) starts a clearing pass over the label store and visit
// marks; no item is accepted until it ends, config writes are.
`timescale 1ns / 1ps

module lattice_split_check_core #(
	parameter int MAX_SITES  = lsc_pkg::MAX_SITES_DEF,
	parameter int LABEL_BITS = lsc_pkg::LABEL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lsc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output lsc_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsc_pkg::DIM_W-1:0]       cfg_data
);

	lsc_pkg::cmd_t  cmd;
	lsc_pkg::stat_t stat;
	logic           idle;
	logic           in_acc;

	// Input is taken only while the controller idles; every query runs to its result.
	assign in_stall = !idle;
	assign in_acc   = in_valid && !in_stall;

	lsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle)
	);

	// Datapath holds the three memories, the ring registers and the result register.
	lsc_dp #(
		.MAX_SITES  (MAX_SITES),
		.LABEL_BITS (LABEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// A write item never raises a result.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.op == lsc_pkg::OP_WRITE && !out_valid |=> !out_valid)
		else $error("result raised by a write item");

	// A query holds off the input until its result is loaded.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.op == lsc_pkg::OP_QUERY |=> in_stall)
		else $error("input taken during a query");

	// Loading a result returns the controller to idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result loaded while not idle");

	// Controller command and input handshake agree.
	a_take_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take == in_acc)
		else $error("controller take out of step with handshake");

endmodule

// File: rtl/core/lsc_div.sv
// Restoring divider, one quotient bit a cycle: site index into row and column.
// Depends on lsc_pkg for widths.
`timescale 1ns / 1ps

module lsc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lsc_pkg::SITE_W-1:0]        dividend,
	input  logic [lsc_pkg::DIM_W-1:0]         divisor,
	output logic                              busy,
	output logic [lsc_pkg::SITE_W-1:0]        quot,
	output logic [lsc_pkg::POS_W-1:0]         rem
);

	logic                           busy_q;
	logic [3:0]                     cnt_q;
	logic [lsc_pkg::SITE_W-1:0]     quo_q;
	logic [lsc_pkg::DIM_W-1:0]      rem_q;
	logic [lsc_pkg::DIM_W-1:0]      div_q;
	logic [lsc_pkg::DIM_W-1:0]      trial;
	logic                           fits;

	assign trial = {rem_q[lsc_pkg::POS_W-1:0], quo_q[lsc_pkg::SITE_W-1]};
	assign fits  = trial >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(lsc_pkg::SITE_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lsc_pkg::SITE_W-2:0], fits};
			rem_q <= fits ? (trial - div_q) : trial;
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q[lsc_pkg::POS_W-1:0];

endmodule

// File: rtl/core/lsc_dp.sv
// Datapath: label store, visit marks, frontier queue, ring registers and result register.
// Depends on lsc_pkg and lsc_div; driven by commands from lsc_ctrl.
`timescale 1ns / 1ps

module lsc_dp #(
	parameter int MAX_SITES  = lsc_pkg::MAX_SITES_DEF,
	parameter int LABEL_BITS = lsc_pkg::LABEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsc_pkg::cmd_t                     cmd,
	output lsc_pkg::stat_t                    stat,
	input  lsc_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lsc_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsc_pkg::DIM_W-1:0]         cfg_data
);

	localparam int IDX_W = $clog2(MAX_SITES);
	localparam int PTR_W = $clog2(MAX_SITES + 1);

	localparam int NB = lsc_pkg::NB_IDX_W;
	localparam int PW = lsc_pkg::POS_W;
	localparam int SW = lsc_pkg::SITE_W;
	localparam int RN = lsc_pkg::RING_N;

	logic [LABEL_BITS-1:0] label_mem [MAX_SITES];
	logic                  vis_mem   [MAX_SITES];
	logic [SW-1:0]         queue_mem [MAX_SITES];

	logic [lsc_pkg::DIM_W-1:0] w_q, h_q, w_eff, h_eff;
	logic [LABEL_BITS-1:0]     lab_q;
	logic [SW-1:0]             site_q;
	logic [PW-1:0]             base_r_q, base_c_q;
	logic [lsc_pkg::DIR_W-1:0] dir_q;
	logic                      nb_inb_q;
	logic [NB-1:0]             nb_idx_q;
	logic [SW-1:0]             nb_pos_q;
	logic [LABEL_BITS-1:0]     lbl_rd_q;
	logic                      vis_rd_q;
	logic [RN-1:0]             mem_q, reached_q;
	logic [NB-1:0]             ring_idx_q [RN];
	logic [SW-1:0]             ring_pos_q [RN];
	logic [PTR_W-1:0]          head_q, tail_q, clr_q, sweep_q;
	logic [SW-1:0]             qd_q;
	logic                      split_q;
	logic                      out_valid_q;
	lsc_pkg::out_item_t        out_q;

	logic                      div_busy;
	logic [SW-1:0]             div_quot;
	logic [PW-1:0]             div_rem;

	lsc_pkg::act_t             act;
	lsc_pkg::nb_t              nb;
	logic [NB-1:0]             nb_idx, clr_idx;
	logic                      nb_inb;
	logic [lsc_pkg::DIR_W-1:0] start_n;
	logic [3:0]                entries;
	logic [RN-1:0]             hit;
	logic                      lbl_match, take_nb;

	assign act   = cmd.act;
	assign w_eff = lsc_pkg::dim_eff(w_q);
	assign h_eff = lsc_pkg::dim_eff(h_q);

	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (act == lsc_pkg::A_QUERY),
		.dividend (in_data.site),
		.divisor  (w_eff),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= lsc_pkg::DIM_MAX;
			h_q <= lsc_pkg::DIM_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsc_pkg::CFG_GRID_WIDTH:  w_q <= cfg_data;
				lsc_pkg::CFG_GRID_HEIGHT: h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Neighbour of the current base position in the current direction.
	always_comb begin
		nb      = lsc_pkg::nb_step(base_r_q, base_c_q, dir_q);
		nb_idx  = NB'(nb.nr[PW-1:0]) * NB'(w_eff) + NB'(nb.nc[PW-1:0]);
		nb_inb  = (nb.nr < h_eff) && (nb.nc < w_eff) && (32'(nb_idx) < 32'(MAX_SITES));
		clr_idx = NB'(qd_q[SW-1:PW]) * NB'(w_eff) + NB'(qd_q[PW-1:0]);
	end

	always_comb begin
		start_n = '0;
		entries = '0;
		for (int i = 0; i < RN; i++) begin
			if (mem_q[i]) start_n = lsc_pkg::DIR_W'(i);
			entries = entries + {3'd0, !mem_q[(i + RN - 1) % RN] && mem_q[i]};
			hit[i]  = mem_q[i] && (ring_idx_q[i] == nb_idx_q);
		end
	end

	assign lbl_match = lbl_rd_q == lab_q;
	assign take_nb   = nb_inb_q && lbl_match && !vis_rd_q && (nb_idx_q != NB'(site_q));

	// Label store: cleared by the sweep after reset, written by write items.
	always_ff @(posedge clk) begin
		if (act == lsc_pkg::A_SWEEP)
			label_mem[sweep_q[IDX_W-1:0]] <= '0;
		else if (act == lsc_pkg::A_WRITE && 32'(in_data.site) < 32'(MAX_SITES))
			label_mem[IDX_W'(in_data.site)] <= LABEL_BITS'(in_data.cell_label);
		if (act == lsc_pkg::A_NB_RD)
			lbl_rd_q <= label_mem[IDX_W'(nb_idx)];
	end

	// Visit marks: cleared by the sweep after reset, set on enqueue, cleared back by walking the queue.
	always_ff @(posedge clk) begin
		unique case (act)
			lsc_pkg::A_SWEEP:  vis_mem[sweep_q[IDX_W-1:0]] <= 1'b0;
			lsc_pkg::A_SEED:   vis_mem[IDX_W'(ring_idx_q[start_n])] <= 1'b1;
			lsc_pkg::A_NB_EV:  if (take_nb) vis_mem[IDX_W'(nb_idx_q)] <= 1'b1;
			lsc_pkg::A_CLR_WR: vis_mem[IDX_W'(clr_idx)] <= 1'b0;
			default: ;
		endcase
		if (act == lsc_pkg::A_NB_RD)
			vis_rd_q <= vis_mem[IDX_W'(nb_idx)];
	end

	// Frontier queue, held as row and column.
	always_ff @(posedge clk) begin
		if (act == lsc_pkg::A_SEED)
			queue_mem[0] <= ring_pos_q[start_n];
		else if (act == lsc_pkg::A_NB_EV && take_nb)
			queue_mem[tail_q[IDX_W-1:0]] <= nb_pos_q;
		if (act == lsc_pkg::A_POP_RD)
			qd_q <= queue_mem[head_q[IDX_W-1:0]];
		else if (act == lsc_pkg::A_CLR_RD)
			qd_q <= queue_mem[clr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		unique case (act)
			lsc_pkg::A_QUERY: begin
				lab_q  <= LABEL_BITS'(in_data.cell_label);
				site_q <= in_data.site;
			end
			lsc_pkg::A_RING_BASE: begin
				base_r_q <= div_quot[PW-1:0];
				base_c_q <= div_rem;
			end
			lsc_pkg::A_POP_LATCH: begin
				base_r_q <= qd_q[SW-1:PW];
				base_c_q <= qd_q[PW-1:0];
			end
			lsc_pkg::A_NB_RD: begin
				nb_inb_q <= nb_inb;
				nb_idx_q <= nb_idx;
				nb_pos_q <= {nb.nr[PW-1:0], nb.nc[PW-1:0]};
			end
			lsc_pkg::A_RING_EV: begin
				ring_idx_q[dir_q] <= nb_idx_q;
				ring_pos_q[dir_q] <= nb_pos_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			dir_q       <= '0;
			mem_q       <= '0;
			reached_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			split_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (act == lsc_pkg::A_LOAD_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (act)
				lsc_pkg::A_SWEEP: sweep_q <= sweep_q + PTR_W'(1);
				lsc_pkg::A_QUERY: split_q <= 1'b0;
				lsc_pkg::A_RING_BASE: begin
					dir_q     <= '0;
					mem_q     <= '0;
					reached_q <= '0;
				end
				lsc_pkg::A_RING_EV: begin
					mem_q[dir_q] <= nb_inb_q && lbl_match;
					dir_q        <= dir_q + lsc_pkg::DIR_W'(1);
				end
				lsc_pkg::A_SEED: begin
					head_q    <= '0;
					tail_q    <= PTR_W'(1);
					reached_q <= RN'(1) << start_n;
				end
				lsc_pkg::A_POP_RD: head_q <= head_q + PTR_W'(1);
				lsc_pkg::A_POP_LATCH: dir_q <= '0;
				lsc_pkg::A_NB_EV: begin
					dir_q <= dir_q + lsc_pkg::DIR_W'(1);
					if (take_nb) begin
						tail_q    <= tail_q + PTR_W'(1);
						reached_q <= reached_q | hit;
					end
				end
				lsc_pkg::A_FLOOD_END: begin
					split_q <= |(mem_q & ~reached_q);
					clr_q   <= '0;
				end
				lsc_pkg::A_CLR_RD: clr_q <= clr_q + PTR_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (act == lsc_pkg::A_LOAD_OUT) begin
			out_q.split      <= split_q;
			out_q.query_site <= site_q;
		end
	end

	always_comb begin
		stat.sweep_last  = sweep_q == PTR_W'(MAX_SITES - 1);
		stat.div_busy    = div_busy;
		stat.site_off    = (div_quot >= SW'(h_eff)) || (32'(site_q) >= 32'(MAX_SITES));
		stat.dir_last    = dir_q == lsc_pkg::DIR_W'(RN - 1);
		stat.entries_gt1 = entries > 4'd1;
		stat.queue_empty = head_q == tail_q;
		stat.all_reached = (mem_q & ~reached_q) == '0;
		stat.clr_done    = clr_q == tail_q;
		stat.out_busy    = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/lsc_ctrl.sv
// Controller state machine: sequences clear pass, ring scan, flood and mark cleanup.
// Depends on lsc_pkg; talks to lsc_dp through cmd_t and stat_t only.
`timescale 1ns / 1ps

module lsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	input  lsc_pkg::stat_t  stat,
	output lsc_pkg::cmd_t   cmd,
	output logic            idle
);

	lsc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lsc_pkg::S_SWEEP;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd.act     = lsc_pkg::A_NONE;
		cmd.in_take = 1'b0;
		idle        = 1'b0;
		unique case (state_q)
			lsc_pkg::S_SWEEP: begin
				cmd.act = lsc_pkg::A_SWEEP;
				if (stat.sweep_last) state_d = lsc_pkg::S_IDLE;
			end
			lsc_pkg::S_IDLE: begin
				idle = 1'b1;
				if (in_valid) begin
					cmd.in_take = 1'b1;
					if (in_op == lsc_pkg::OP_QUERY) begin
						cmd.act = lsc_pkg::A_QUERY;
						state_d = lsc_pkg::S_DIV;
					end else begin
						cmd.act = lsc_pkg::A_WRITE;
					end
				end
			end
			lsc_pkg::S_DIV: begin
				if (!stat.div_busy) begin
					if (stat.site_off) begin
						state_d = lsc_pkg::S_DONE;
					end else begin
						cmd.act = lsc_pkg::A_RING_BASE;
						state_d = lsc_pkg::S_RING_RD;
					end
				end
			end
			lsc_pkg::S_RING_RD: begin
				cmd.act = lsc_pkg::A_NB_RD;
				state_d = lsc_pkg::S_RING_EV;
			end
			lsc_pkg::S_RING_EV: begin
				cmd.act = lsc_pkg::A_RING_EV;
				state_d = stat.dir_last ? lsc_pkg::S_RING_END : lsc_pkg::S_RING_RD;
			end
			lsc_pkg::S_RING_END: begin
				if (stat.entries_gt1) begin
					cmd.act = lsc_pkg::A_SEED;
					state_d = lsc_pkg::S_POP;
				end else begin
					state_d = lsc_pkg::S_DONE;
				end
			end
			lsc_pkg::S_POP: begin
				if (stat.queue_empty || stat.all_reached) begin
					cmd.act = lsc_pkg::A_FLOOD_END;
					state_d = lsc_pkg::S_CLR_RD;
				end else begin
					cmd.act = lsc_pkg::A_POP_RD;
					state_d = lsc_pkg::S_POP_W;
				end
			end
			lsc_pkg::S_POP_W: begin
				cmd.act = lsc_pkg::A_POP_LATCH;
				state_d = lsc_pkg::S_NB_RD;
			end
			lsc_pkg::S_NB_RD: begin
				cmd.act = lsc_pkg::A_NB_RD;
				state_d = lsc_pkg::S_NB_EV;
			end
			lsc_pkg::S_NB_EV: begin
				cmd.act = lsc_pkg::A_NB_EV;
				state_d = stat.dir_last ? lsc_pkg::S_POP : lsc_pkg::S_NB_RD;
			end
			lsc_pkg::S_CLR_RD: begin
				if (stat.clr_done) begin
					state_d = lsc_pkg::S_DONE;
				end else begin
					cmd.act = lsc_pkg::A_CLR_RD;
					state_d = lsc_pkg::S_CLR_WR;
				end
			end
			lsc_pkg::S_CLR_WR: begin
				cmd.act = lsc_pkg::A_CLR_WR;
				state_d = lsc_pkg::S_CLR_RD;
			end
			lsc_pkg::S_DONE: begin
				if (!stat.out_busy) begin
					cmd.act = lsc_pkg::A_LOAD_OUT;
					state_d = lsc_pkg::S_IDLE;
				end
			end
			default: state_d = lsc_pkg::S_IDLE;
		endcase
	end

endmodule

// File: bench/lattice_split_check_core_tb.sv
// Self-checking bench for lattice_split_check_core: directed table plus random phases.
// Depends on lsc_pkg (item types, config indexes, op codes) and the core itself.
`timescale 1ns / 1ps

module lattice_split_check_core_tb;

	localparam int SITES       = 4096;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RAND_ITEMS  = 125;   // per random phase, six phases
	localparam int SETTLE      = 50;
	localparam int DIR_ROWS    = 20;
	localparam int RING_DC [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
	localparam int RING_DR [8] = '{1, 1, 1, 0, -1, -1, -1, 0};

	typedef struct {
		logic       op;
		int         site;
		int         lab;
		bit         known;      // expected split typed in below
		logic       split_exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lsc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lsc_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index = lsc_pkg::CFG_GRID_WIDTH;
	logic [lsc_pkg::DIM_W-1:0] cfg_data = '0;

	// Shadow of the lattice and the grid registers.
	logic [7:0] lattice [SITES];
	logic [1:0] flood_mark [SITES];
	int flood_fifo [SITES];
	int grid_w = 64;
	int grid_h = 64;

	lsc_pkg::out_item_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	lattice_split_check_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Abort on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Random back-pressure on the result side.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic int clamp_dim(input int v);
		return (v < 3) ? 3 : ((v > 64) ? 64 : v);
	endfunction

	// Linear index of (r, c), or -1 off the lattice.
	function automatic int lattice_index(input int r, input int c);
		int idx;
		if (r < 0 || c < 0 || r >= grid_h || c >= grid_w) return -1;
		idx = r * grid_w + c;
		return (idx >= SITES) ? -1 : idx;
	endfunction

	function automatic bit in_cell(input int r, input int c, input logic [7:0] lab);
		int idx;
		idx = lattice_index(r, c);
		if (idx < 0) return 1'b0;
		return lattice[idx] == lab;
	endfunction

	// Would removing the site cut the cell into pieces?
	function automatic logic cell_splits(input int site, input logic [7:0] lab);
		int r0, c0, n, entries, ring_left, head, tail, seed, nb, g, gr, gc;
		bit prev, curr;
		r0 = site / grid_w;
		c0 = site % grid_w;
		if (lattice_index(r0, c0) < 0) return 1'b0;
		entries = 0;
		prev = in_cell(r0 + RING_DR[7], c0 + RING_DC[7], lab);
		for (n = 0; n < 8; n++) begin
			curr = in_cell(r0 + RING_DR[n], c0 + RING_DC[n], lab);
			if (!prev && curr) entries++;
			prev = curr;
		end
		if (entries <= 1) return 1'b0;
		// marks: 0 ring member, 1 unvisited, 2 queued, 3 done
		for (n = 0; n < SITES; n++) flood_mark[n] = 2'd1;
		flood_mark[site] = 2'd3;
		ring_left = 0;
		seed = -1;
		for (n = 0; n < 8; n++) begin
			nb = lattice_index(r0 + RING_DR[n], c0 + RING_DC[n]);
			if (nb >= 0 && lattice[nb] == lab) begin
				flood_mark[nb] = 2'd0;
				ring_left++;
				seed = nb;
			end
		end
		ring_left--;
		flood_mark[seed] = 2'd2;
		head = 0;
		tail = 1;
		flood_fifo[0] = seed;
		while (head < tail && ring_left > 0) begin
			g = flood_fifo[head];
			head++;
			gr = g / grid_w;
			gc = g % grid_w;
			for (n = 0; n < 8; n++) begin
				nb = lattice_index(gr + RING_DR[n], gc + RING_DC[n]);
				if (nb >= 0 && lattice[nb] == lab && flood_mark[nb] < 2'd2) begin
					if (flood_mark[nb] == 2'd0) ring_left--;
					flood_mark[nb] = 2'd2;
					if (tail < SITES) begin
						flood_fifo[tail] = nb;
						tail++;
					end
				end
			end
			flood_mark[g] = 2'd3;
		end
		return ring_left > 0;
	endfunction

	// Drive one item, hold it through stalls, then book its effect.
	task automatic send_item(input lsc_pkg::in_item_t it, input bit known, input logic split_exp);
		lsc_pkg::out_item_t res;
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		if (it.op == lsc_pkg::OP_WRITE) begin
			lattice[it.site] = it.cell_label;
		end else begin
			res.split = known ? split_exp : cell_splits(it.site, it.cell_label);
			res.query_site = it.site;
			pending_results.push_back(res);
		end
	endtask

	// Drop valid and wait until every result is back, plus slack for a trailing write.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lsc_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[lsc_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lsc_pkg::CFG_GRID_WIDTH) grid_w = clamp_dim(value);
		else grid_h = clamp_dim(value);
	endtask

	function automatic logic [7:0] pick_label(input bit no_medium);
		logic [7:0] l;
		case ($urandom_range(9))
			0: l = 8'($urandom_range(255));
			1, 2: l = 8'd0;
			default: l = 8'($urandom_range(1, 3));
		endcase
		if (no_medium && l == 8'd0) l = 8'd1;
		return l;
	endfunction

	// Random sequence for one grid setting: clustered writes of a few labels and queries.
	task automatic random_phase(input bit pause_once);
		lsc_pkg::in_item_t it;
		int k, rows;
		bit wide;
		wide = grid_w * grid_h > 256;
		rows = wide ? 8 : grid_h;   // keep cells small on the big lattices
		for (k = 0; k < RAND_ITEMS; k++) begin
			it.op = ($urandom_range(99) < 40) ? lsc_pkg::OP_QUERY : lsc_pkg::OP_WRITE;
			if ($urandom_range(9) == 0)
				it.site = lsc_pkg::SITE_W'($urandom_range(4095));
			else
				it.site = lsc_pkg::SITE_W'($urandom_range(rows - 1) * grid_w
					+ $urandom_range(grid_w - 1));
			it.cell_label = pick_label(wide && it.op == lsc_pkg::OP_QUERY);
			if (pause_once && k == RAND_ITEMS / 2) begin
				// hold off the sender until the pipe is empty
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			send_item(it, 1'b0, 1'b0);
		end
		drain();
	endtask

	// Check each result as it leaves; values are stable at the falling edge.
	always @(negedge clk) begin
		lsc_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no query pending: site %0d", out_data.query_site);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.split !== want.split) begin
					$error("split: expected %0b, got %0b", want.split, out_data.split);
					errors++;
				end
				if (out_data.query_site !== want.query_site) begin
					$error("query_site: expected %0d, got %0d",
						want.query_site, out_data.query_site);
					errors++;
				end
			end
		end
	end

	dir_row_t directed [DIR_ROWS] = '{
		'{lsc_pkg::OP_QUERY, 0,    0,   1, 1'b0},   // corner of an empty lattice
		'{lsc_pkg::OP_QUERY, 4095, 255, 1, 1'b0},   // far corner, absent label
		'{lsc_pkg::OP_QUERY, 4095, 0,   1, 1'b0},
		'{lsc_pkg::OP_WRITE, 0,    5,   0, 1'b0},
		'{lsc_pkg::OP_WRITE, 130,  5,   0, 1'b0},
		'{lsc_pkg::OP_QUERY, 65,   5,   1, 1'b1},   // two diagonal pieces joined only by the site
		'{lsc_pkg::OP_WRITE, 1,    5,   0, 1'b0},
		'{lsc_pkg::OP_QUERY, 65,   5,   0, 1'b0},
		'{lsc_pkg::OP_WRITE, 66,   5,   0, 1'b0},
		'{lsc_pkg::OP_QUERY, 65,   5,   0, 1'b0},   // bridged around the site
		'{lsc_pkg::OP_WRITE, 4095, 255, 0, 1'b0},
		'{lsc_pkg::OP_WRITE, 4031, 255, 0, 1'b0},
		'{lsc_pkg::OP_WRITE, 4093, 255, 0, 1'b0},
		'{lsc_pkg::OP_QUERY, 4094, 255, 0, 1'b0},
		'{lsc_pkg::OP_QUERY, 4030, 0,   0, 1'b0},   // medium as the queried cell
		'{lsc_pkg::OP_WRITE, 63,   7,   0, 1'b0},
		'{lsc_pkg::OP_WRITE, 64,   7,   0, 1'b0},
		'{lsc_pkg::OP_QUERY, 0,    7,   0, 1'b0},   // no wrap between rows
		'{lsc_pkg::OP_WRITE, 2047, 170, 0, 1'b0},
		'{lsc_pkg::OP_QUERY, 2048, 85,  0, 1'b0}
	};

	initial begin
		lsc_pkg::in_item_t it;
		int i;
		for (i = 0; i < SITES; i++) lattice[i] = 8'd0;
		send_idle_pct = 8;
		recv_idle_pct = 76;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			it.op = directed[i].op;
			it.site = lsc_pkg::SITE_W'(directed[i].site);
			it.cell_label = lsc_pkg::LABEL_W'(directed[i].lab);
			send_item(it, directed[i].known, directed[i].split_exp);
		end
		drain();

		random_phase(1'b0);                        // reset size 64 x 64
		write_reg(lsc_pkg::CFG_GRID_WIDTH, 3);
		write_reg(lsc_pkg::CFG_GRID_HEIGHT, 3);
		random_phase(1'b1);
		write_reg(lsc_pkg::CFG_GRID_WIDTH, 0);     // clamps to 3
		write_reg(lsc_pkg::CFG_GRID_HEIGHT, 8);
		send_idle_pct = 76;
		recv_idle_pct = 8;
		random_phase(1'b0);
		write_reg(lsc_pkg::CFG_GRID_WIDTH, 8);
		write_reg(lsc_pkg::CFG_GRID_HEIGHT, 2);    // clamps to 3
		random_phase(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(lsc_pkg::CFG_GRID_WIDTH, 127);   // clamps to 64
		write_reg(lsc_pkg::CFG_GRID_HEIGHT, 5);
		random_phase(1'b0);
		write_reg(lsc_pkg::CFG_GRID_WIDTH, 16);
		write_reg(lsc_pkg::CFG_GRID_HEIGHT, 100);  // clamps to 64
		random_phase(1'b0);

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/lsc_pkg.sv
rtl/core/lsc_div.sv
rtl/core/lsc_dp.sv
rtl/core/lsc_ctrl.sv
rtl/core/lattice_split_check_core.sv
bench/lattice_split_check_core_tb.sv
